FILE: src/isp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isp_pkg: shared types and constants for the image segment packetizer
// Transaction payloads, the internal packet job and the ASCII header helpers.
// ----------------------------------------------------------------------------
package isp_pkg;

	localparam int HEADER_BYTES = 10;
	localparam logic [3:0] HDR_LEN = 4'd10;

	localparam logic [1:0] REQ_BYTE   = 2'd0;
	localparam logic [1:0] REQ_RESEND = 2'd1;
	localparam logic [1:0] REQ_TICK   = 2'd2;

	localparam logic [7:0] CHAR_0 = 8'h30;
	localparam logic [7:0] CHAR_A = 8'h41;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  data_byte;
		logic [11:0] segment_id;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       packet_end;
	} result_t;

	// one queued piece of output work: header run, payload byte or both
	typedef struct packed {
		logic [11:0] seg;
		logic [15:0] bcd;
		logic [3:0]  pos;
		logic        hdr_only;
		logic        src_ram;
		logic [7:0]  data;
		logic        pkt_end;
	} job_t;

	typedef struct packed {
		logic [11:0] tot_hex;
		logic [15:0] last_bcd;
	} hdr_info_t;

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		return (v < 4'd10) ? CHAR_0 + {4'd0, v} : CHAR_A + {4'd0, v - 4'd10};
	endfunction

	function automatic logic [7:0] dec_char(input logic [3:0] d);
		return CHAR_0 + {4'd0, d};
	endfunction

	function automatic logic [7:0] header_char(input logic [3:0] pos, input logic [11:0] tot,
			input logic [11:0] seg, input logic [15:0] bcd);
		logic [7:0] c;
		unique case (pos)
			4'd0: c = hex_char(tot[11:8]);
			4'd1: c = hex_char(tot[7:4]);
			4'd2: c = hex_char(tot[3:0]);
			4'd3: c = hex_char(seg[11:8]);
			4'd4: c = hex_char(seg[7:4]);
			4'd5: c = hex_char(seg[3:0]);
			4'd6: c = dec_char(bcd[15:12]);
			4'd7: c = dec_char(bcd[11:8]);
			4'd8: c = dec_char(bcd[7:4]);
			default: c = dec_char(bcd[3:0]);
		endcase
		return c;
	endfunction

endpackage

FILE: src/isp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isp_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module isp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/isp_setup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isp_setup: frame length setup sequencer
// Holds the image length, divides it by the payload size with a reciprocal
// multiply, takes the remainder and converts the last packet length to BCD
// for the header.
// ----------------------------------------------------------------------------
module isp_setup #(
	parameter int IMAGE_DEPTH  = 65536,
	parameter int PACKET_BYTES = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr,
	input  logic [16:0]                           cfg_len,
	output logic                                  done,
	output logic [$clog2(IMAGE_DEPTH+1)-1:0]      eff_len,
	output logic [$clog2(IMAGE_DEPTH+1)-1:0]      total,
	output logic [$clog2(PACKET_BYTES+1)-1:0]     last_len,
	output isp_pkg::hdr_info_t                    info
);

	import isp_pkg::*;

	localparam int LW      = $clog2(IMAGE_DEPTH + 1);
	localparam int PW      = $clog2(PACKET_BYTES + 1);
	localparam int PAYLOAD = PACKET_BYTES - HEADER_BYTES;
	localparam int CW      = (LW > 17) ? LW + 1 : 18;
	localparam int CNTW    = $clog2(PW);
	localparam int RST_EFF = (65536 > IMAGE_DEPTH) ? IMAGE_DEPTH : 65536;
	localparam int SH      = LW + $clog2(PAYLOAD);
	localparam int PRW     = SH + LW;
	localparam int BW      = LW + PW;
	localparam logic [63:0] RECIP64 =
		((64'd1 << SH) + 64'(PAYLOAD) - 64'd1) / 64'(PAYLOAD);
	localparam logic [PRW-1:0] RECIP = PRW'(RECIP64);

	typedef enum logic [2:0] {ST_DIV, ST_REM, ST_FIX, ST_BCD, ST_DONE} state_t;

	state_t          state_q;
	logic [LW-1:0]   eff_q;
	logic [LW-1:0]   quo_q;
	logic [PW-1:0]   rem_q;
	logic [CNTW-1:0] cnt_q;
	logic [LW-1:0]   tot_q;
	logic [PW-1:0]   last_len_q;
	logic [PW-1:0]   bin_q;
	logic [15:0]     bcd_q;

	logic [LW-1:0]   eff_new;
	logic [PRW-1:0]  recip_prod;
	logic [BW-1:0]   back_prod;
	logic [LW-1:0]   rem_new;
	logic [PW-1:0]   last_new;
	logic [15:0]     bcd_adj;

	function automatic logic [15:0] dd_adjust(input logic [15:0] v);
		logic [15:0] r;
		r = v;
		for (int i = 0; i < 4; i++) begin
			if (r[4*i +: 4] >= 4'd5) begin
				r[4*i +: 4] = r[4*i +: 4] + 4'd3;
			end
		end
		return r;
	endfunction

	assign eff_new    = (CW'(cfg_len) > CW'(IMAGE_DEPTH)) ? LW'(IMAGE_DEPTH) : LW'(cfg_len);
	// quotient exact for every LW-bit length
	assign recip_prod = PRW'(eff_q) * RECIP;
	assign back_prod  = BW'(quo_q) * BW'(PAYLOAD);
	assign rem_new    = eff_q - back_prod[LW-1:0];
	assign last_new   = (rem_q == '0) ? PW'(PACKET_BYTES) : rem_q + PW'(HEADER_BYTES);
	assign bcd_adj    = dd_adjust(bcd_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_DIV;
			eff_q      <= LW'(RST_EFF);
			quo_q      <= '0;
			rem_q      <= '0;
			cnt_q      <= '0;
			tot_q      <= '0;
			last_len_q <= '0;
			bin_q      <= '0;
			bcd_q      <= '0;
		end else if (cfg_wr) begin
			state_q <= ST_DIV;
			eff_q   <= eff_new;
			rem_q   <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_DIV: begin
					quo_q   <= recip_prod[SH +: LW];
					state_q <= ST_REM;
				end
				ST_REM: begin
					rem_q   <= PW'(rem_new);
					state_q <= ST_FIX;
				end
				ST_FIX: begin
					tot_q      <= quo_q + LW'(rem_q != '0);
					last_len_q <= last_new;
					bin_q      <= last_new;
					bcd_q      <= '0;
					cnt_q      <= '0;
					state_q    <= ST_BCD;
				end
				ST_BCD: begin
					bcd_q <= {bcd_adj[14:0], bin_q[PW-1]};
					bin_q <= bin_q << 1;
					cnt_q <= cnt_q + CNTW'(1);
					if (cnt_q == CNTW'(PW - 1)) begin
						state_q <= ST_DONE;
					end
				end
				default: ;
			endcase
		end
	end

	assign done          = (state_q == ST_DONE);
	assign eff_len       = eff_q;
	assign total         = tot_q;
	assign last_len      = last_len_q;
	assign info.tot_hex  = 12'(tot_q);
	assign info.last_bcd = bcd_q;

endmodule

FILE: src/isp_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isp_emit: packet byte emitter
// Holds one job, expands header runs into ASCII bytes and feeds the output
// register, one byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module isp_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	input  isp_pkg::job_t      job,
	output logic               job_ready,
	input  logic [7:0]         rdata,
	input  logic [11:0]        tot_hex,
	output logic               result_valid,
	input  logic               result_ready,
	output isp_pkg::result_t   result
);

	import isp_pkg::*;

	job_t    s1_q;
	logic    s1_valid_q;
	result_t out_q;
	logic    out_valid_q;

	logic    out_free;
	logic    step;
	logic    in_hdr;
	logic    job_done;
	result_t next_out;

	assign out_free  = !out_valid_q || result_ready;
	assign step      = s1_valid_q && out_free;
	assign in_hdr    = s1_q.pos < HDR_LEN;
	assign job_done  = step && (s1_q.hdr_only || !in_hdr);
	assign job_ready = !s1_valid_q || job_done;

	always_comb begin
		if (in_hdr) begin
			next_out.out_byte   = header_char(s1_q.pos, tot_hex, s1_q.seg, s1_q.bcd);
			next_out.packet_end = 1'b0;
		end else begin
			next_out.out_byte   = s1_q.src_ram ? rdata : s1_q.data;
			next_out.packet_end = s1_q.pkt_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			s1_q        <= '0;
			out_q       <= '0;
		end else begin
			if (job_valid && job_ready) begin
				s1_q       <= job;
				s1_valid_q <= 1'b1;
			end else if (job_done) begin
				s1_valid_q <= 1'b0;
			end else if (step) begin
				s1_q.pos <= s1_q.pos + 4'd1;
			end
			if (step) begin
				out_q       <= next_out;
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_job_offered_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> job_ready)
		else $error("job offered while emitter busy");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> s1_q.pos <= HDR_LEN)
		else $error("emitter position past payload slot");

	a_hdr_no_end: assert property (@(posedge clk) disable iff (!arst_n)
		step && in_hdr |=> out_valid_q && !out_q.packet_end)
		else $error("header byte flagged as packet end");

endmodule

FILE: src/image_segment_packetizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_segment_packetizer: image byte packetizer with segment resend
// Splits an image stream into headered packets, stores each frame byte and
// replays a requested segment one byte per tick.
// ----------------------------------------------------------------------------
// An image byte, a resend request or a tick is taken every cycle while the
// output keeps up; each transaction yields at most one output byte per cycle
// through one output register. An image byte that opens a packet produces
// eleven bytes (ten ASCII header bytes, then the payload byte), so the input
// holds off while the header bytes go out. Resend payload bytes come from the
// image store RAM, read when the tick is taken and passed through the RAM read
// register to the output register. After reset and after each length write
// the setup sequencer runs a reciprocal multiply by the payload size, a
// remainder step, a total step and a BCD conversion of the last packet
// length, during which no transaction is taken on the item channel. Length
// writes are accepted at any time and restart the frame; no item is taken in
// the cycle of a length write.
// ----------------------------------------------------------------------------
module image_segment_packetizer #(
	parameter int IMAGE_DEPTH  = 65536,
	parameter int PACKET_BYTES = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [16:0]       cfg_data,
	input  logic              item_valid,
	output logic              item_ready,
	input  isp_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_ready,
	output isp_pkg::result_t  result
);

	import isp_pkg::*;

	localparam int LW      = $clog2(IMAGE_DEPTH + 1);
	localparam int AW      = $clog2(IMAGE_DEPTH);
	localparam int PW      = $clog2(PACKET_BYTES + 1);
	localparam int PAYLOAD = PACKET_BYTES - HEADER_BYTES;
	localparam int SW      = (LW > 12) ? LW : 12;
	localparam int XW      = ((LW > PW) ? LW : PW) + 1;
	localparam int MW      = (AW > 12 + PW) ? AW : 12 + PW;
	localparam logic [15:0] FULL_BCD = {4'(PACKET_BYTES / 1000 % 10),
		4'(PACKET_BYTES / 100 % 10), 4'(PACKET_BYTES / 10 % 10), 4'(PACKET_BYTES % 10)};

	logic            cfg_wr;
	logic            setup_done;
	logic [LW-1:0]   eff_len;
	logic [LW-1:0]   total;
	logic [PW-1:0]   last_len;
	hdr_info_t       info;

	logic [LW-1:0]   rcv_q;
	logic [PW-1:0]   ppos_q;
	logic [11:0]     cseg_q;
	logic            ract_q;
	logic [11:0]     rseg_q;
	logic [PW-1:0]   rpos_q;
	logic [AW-1:0]   raddr_q;
	logic            rlast_q;

	logic            accept;
	logic            full;
	logic [LW-1:0]   rem;
	logic            byte_last;
	logic            pkt_first;
	logic [11:0]     seg_next;
	logic            byte_end;
	logic            resend_ok;
	logic [11:0]     seg_m1;
	logic [MW-1:0]   prod;
	logic [PW-1:0]   rplen;
	logic            tick_end;
	logic            tick_hdr;

	job_t            job;
	logic            job_valid;
	logic            job_ready;
	logic            ram_we;
	logic            ram_re;
	logic [7:0]      ram_rdata;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	isp_setup #(
		.IMAGE_DEPTH  (IMAGE_DEPTH),
		.PACKET_BYTES (PACKET_BYTES)
	) u_setup (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_wr),
		.cfg_len  (cfg_data),
		.done     (setup_done),
		.eff_len  (eff_len),
		.total    (total),
		.last_len (last_len),
		.info     (info)
	);

	assign item_ready = setup_done && job_ready && !cfg_valid;
	assign accept     = item_valid && item_ready;

	assign full      = rcv_q >= eff_len;
	assign rem       = eff_len - rcv_q;
	assign byte_last = XW'(rem) < XW'(PAYLOAD);
	assign pkt_first = (ppos_q == '0);
	assign seg_next  = cseg_q + 12'd1;
	assign byte_end  = (XW'(ppos_q) + XW'(1) >= XW'(PAYLOAD)) ||
		(XW'(rcv_q) + XW'(1) >= XW'(eff_len));

	assign resend_ok = (eff_len != '0) && (rcv_q == eff_len) && !ract_q &&
		(item.segment_id != '0) && (SW'(item.segment_id) <= SW'(total));
	assign seg_m1    = item.segment_id - 12'd1;
	assign prod      = MW'(seg_m1) * MW'(PAYLOAD);

	assign rplen    = rlast_q ? last_len : PW'(PACKET_BYTES);
	assign tick_end = (XW'(rpos_q) + XW'(1)) >= XW'(rplen);
	assign tick_hdr = rpos_q < PW'(HEADER_BYTES);

	always_comb begin
		job       = '0;
		job_valid = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		if (accept) begin
			unique case (item.req_type)
				REQ_BYTE: begin
					if (!full) begin
						job_valid   = 1'b1;
						job.pos     = pkt_first ? 4'd0 : HDR_LEN;
						job.seg     = seg_next;
						job.bcd     = byte_last ? info.last_bcd : FULL_BCD;
						job.data    = item.data_byte;
						job.pkt_end = byte_end;
						ram_we      = 1'b1;
					end
				end
				REQ_TICK: begin
					if (ract_q) begin
						job_valid = 1'b1;
						job.seg   = rseg_q;
						job.bcd   = rlast_q ? info.last_bcd : FULL_BCD;
						if (tick_hdr) begin
							job.pos      = 4'(rpos_q);
							job.hdr_only = 1'b1;
						end else begin
							job.pos     = HDR_LEN;
							job.src_ram = 1'b1;
							job.pkt_end = tick_end;
							ram_re      = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcv_q   <= '0;
			ppos_q  <= '0;
			cseg_q  <= '0;
			ract_q  <= 1'b0;
			rseg_q  <= '0;
			rpos_q  <= '0;
			raddr_q <= '0;
			rlast_q <= 1'b0;
		end else if (cfg_wr) begin
			rcv_q   <= '0;
			ppos_q  <= '0;
			cseg_q  <= '0;
			ract_q  <= 1'b0;
			rseg_q  <= '0;
			rpos_q  <= '0;
			rlast_q <= 1'b0;
		end else if (accept) begin
			unique case (item.req_type)
				REQ_BYTE: begin
					if (!full) begin
						rcv_q  <= rcv_q + LW'(1);
						ppos_q <= byte_end ? '0 : ppos_q + PW'(1);
						if (pkt_first) begin
							cseg_q <= seg_next;
						end
					end
				end
				REQ_RESEND: begin
					if (resend_ok) begin
						ract_q  <= 1'b1;
						rseg_q  <= item.segment_id;
						rpos_q  <= '0;
						raddr_q <= prod[AW-1:0];
						rlast_q <= (SW'(item.segment_id) == SW'(total));
					end
				end
				REQ_TICK: begin
					if (ract_q) begin
						if (tick_end) begin
							ract_q <= 1'b0;
							rpos_q <= '0;
						end else begin
							rpos_q <= rpos_q + PW'(1);
						end
						if (!tick_hdr) begin
							raddr_q <= raddr_q + AW'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	isp_ram #(
		.WIDTH (8),
		.DEPTH (IMAGE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (rcv_q[AW-1:0]),
		.wdata (item.data_byte),
		.re    (ram_re),
		.raddr (raddr_q),
		.rdata (ram_rdata)
	);

	isp_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (job_valid),
		.job          (job),
		.job_ready    (job_ready),
		.rdata        (ram_rdata),
		.tot_hex      (info.tot_hex),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	a_resend_after_frame: assert property (@(posedge clk) disable iff (!arst_n)
		ract_q |-> rcv_q == eff_len)
		else $error("resend active before frame complete");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		rcv_q <= eff_len)
		else $error("received byte count past frame length");

	a_hold_during_setup: assert property (@(posedge clk) disable iff (!arst_n)
		!setup_done |-> !item_ready)
		else $error("item taken while setup running");

endmodule

FILE: tb/sv/image_segment_packetizer_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_segment_packetizer_check: output predictor and comparator
// Watches the length, request and packet byte channels, keeps its own copy
// of the frame state and the image store, works out the packet bytes each
// accepted request transaction must produce and compares them in order.
// ----------------------------------------------------------------------------
module image_segment_packetizer_check #(
	parameter int IMAGE_DEPTH  = 65536,
	parameter int PACKET_BYTES = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [16:0]      cfg_data,
	input  logic             item_valid,
	input  logic             item_ready,
	input  isp_pkg::item_t   item,
	input  logic             result_valid,
	input  logic             result_ready,
	input  isp_pkg::result_t result,
	output int               errors,
	output int               waiting
);
	import isp_pkg::*;

	localparam int PAYLOAD_BYTES = PACKET_BYTES - HEADER_BYTES;
	localparam logic [8*16-1:0] HEX_DIGITS = "0123456789ABCDEF";

	result_t    pending_bytes[$];
	logic [7:0] image_mem [IMAGE_DEPTH];
	logic [16:0] length_reg;
	logic [16:0] stored_count;
	logic [9:0]  pay_pos;
	logic [11:0] seg_count;
	logic        replay_on;
	logic [11:0] replay_seg;
	logic [10:0] replay_pos;

	function automatic int frame_bytes();
		return (length_reg > IMAGE_DEPTH) ? IMAGE_DEPTH : int'(length_reg);
	endfunction

	function automatic int seg_total();
		return (frame_bytes() + PAYLOAD_BYTES - 1) / PAYLOAD_BYTES;
	endfunction

	function automatic int packet_bytes(input int start);
		int rem;
		rem = frame_bytes() - start;
		return ((rem < PAYLOAD_BYTES) ? rem : PAYLOAD_BYTES) + HEADER_BYTES;
	endfunction

	function automatic logic [7:0] ascii_hex(input logic [3:0] n);
		return HEX_DIGITS[8 * (15 - n) +: 8];
	endfunction

	function automatic logic [7:0] header_char(input int pos, input logic [11:0] sid,
			input int plen);
		logic [11:0] tot;
		tot = 12'(seg_total());
		if (pos < 3)
			return ascii_hex(tot[4 * (2 - pos) +: 4]);
		if (pos < 6)
			return ascii_hex(sid[4 * (5 - pos) +: 4]);
		return CHAR_0 + 8'((plen / (10 ** (9 - pos))) % 10);
	endfunction

	task automatic restart_frame();
		stored_count = '0;
		pay_pos = '0;
		seg_count = '0;
		replay_on = 1'b0;
		replay_seg = '0;
		replay_pos = '0;
	endtask

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $time, msg);
		errors++;
	endtask

	task automatic packetize(input item_t it);
		int plen;
		int start;
		logic last;
		logic [7:0] b;
		case (it.req_type)
			REQ_BYTE: begin
				if (stored_count < frame_bytes()) begin
					if (pay_pos == 0) begin
						plen = packet_bytes(int'(stored_count));
						seg_count = seg_count + 12'd1;
						for (int p = 0; p < HEADER_BYTES; p++)
							pending_bytes.push_back({header_char(p, seg_count, plen), 1'b0});
					end
					image_mem[stored_count] = it.data_byte;
					stored_count = stored_count + 17'd1;
					pay_pos = pay_pos + 10'd1;
					last = (pay_pos >= PAYLOAD_BYTES) || (stored_count >= frame_bytes());
					if (last)
						pay_pos = '0;
					pending_bytes.push_back({it.data_byte, last});
				end
			end
			REQ_RESEND: begin
				if (frame_bytes() != 0 && stored_count == frame_bytes() && !replay_on &&
						it.segment_id != 0 && it.segment_id <= seg_total()) begin
					replay_on = 1'b1;
					replay_seg = it.segment_id;
					replay_pos = '0;
				end
			end
			REQ_TICK: begin
				if (replay_on) begin
					start = (int'(replay_seg) - 1) * PAYLOAD_BYTES;
					plen = packet_bytes(start);
					if (replay_pos < HEADER_BYTES)
						b = header_char(int'(replay_pos), replay_seg, plen);
					else
						b = image_mem[start + int'(replay_pos) - HEADER_BYTES];
					last = (int'(replay_pos) + 1 >= plen);
					pending_bytes.push_back({b, last});
					if (last) begin
						replay_on = 1'b0;
						replay_pos = '0;
					end else begin
						replay_pos = replay_pos + 11'd1;
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_result();
		result_t want;
		if (pending_bytes.size() == 0) begin
			report_mismatch($sformatf("unexpected byte %02h end %0b",
				result.out_byte, result.packet_end));
		end else begin
			want = pending_bytes.pop_front();
			if (result.out_byte != want.out_byte)
				report_mismatch($sformatf("out_byte %02h, expected %02h",
					result.out_byte, want.out_byte));
			if (result.packet_end != want.packet_end)
				report_mismatch($sformatf("packet_end %0b, expected %0b (byte %02h)",
					result.packet_end, want.packet_end, want.out_byte));
		end
	endtask

	// push before compare so a same-edge result still finds its expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_reg = 17'd65536;
			restart_frame();
			pending_bytes.delete();
			errors = 0;
			waiting <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				length_reg = cfg_data;
				restart_frame();
			end
			if (item_valid && item_ready)
				packetize(item);
			if (result_valid && result_ready)
				check_result();
			waiting <= pending_bytes.size();
		end
	end

endmodule

FILE: tb/sv/image_segment_packetizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_segment_packetizer_tb: top level of the packetizer testbench
// Drives frame lengths, image bytes, resend requests and ticks with random
// gaps and output stalls; a separate check module predicts and compares.
// ----------------------------------------------------------------------------
module image_segment_packetizer_tb;
	import isp_pkg::*;

	localparam int IMAGE_DEPTH   = 65536;
	localparam int PACKET_BYTES  = 1024;
	localparam int PAYLOAD_BYTES = PACKET_BYTES - HEADER_BYTES;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS  = 260;
	localparam int SETTLE_CYCLES = 32;
	localparam int STALL_LIMIT   = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [16:0] cfg_data = '0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	item_t       item = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	result_t     result;

	int errors;
	int waiting;
	int frame_len;
	int stim_count;
	int len;
	bit tx_calm;
	bit rx_calm;
	int rx_draw;
	int rx_hold;
	int idle_cycles;

	image_segment_packetizer #(
		.IMAGE_DEPTH(IMAGE_DEPTH),
		.PACKET_BYTES(PACKET_BYTES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	image_segment_packetizer_check #(
		.IMAGE_DEPTH(IMAGE_DEPTH),
		.PACKET_BYTES(PACKET_BYTES)
	) packet_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.errors(errors),
		.waiting(waiting)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// packet byte sink: a random stall after each accepted byte, with calm stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			rx_hold <= 0;
			rx_calm <= 1'b0;
		end else if (result_valid && result_ready) begin
			if ($urandom_range(0, 39) == 0)
				rx_calm <= !rx_calm;
			rx_draw = rx_calm ? 0 : $urandom_range(0, 4);
			result_ready <= (rx_draw == 0);
			rx_hold <= rx_draw;
		end else if (!result_ready) begin
			if (rx_hold <= 1)
				result_ready <= 1'b1;
			rx_hold <= rx_hold - 1;
		end
	end

	always @(posedge clk) begin
		if ((cfg_valid && cfg_ready) || (item_valid && item_ready) ||
				(result_valid && result_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	function automatic item_t make_item(input logic [1:0] req, input logic [7:0] data,
			input logic [11:0] seg);
		item_t it;
		it.req_type = req;
		it.data_byte = data;
		it.segment_id = seg;
		return it;
	endfunction

	task automatic send_item(input item_t it);
		int gap;
		if ($urandom_range(0, 39) == 0)
			tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_length(input int value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= 17'(value);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		frame_len = value;
	endtask

	// requests the block must drop in the current phase
	task automatic send_noise(input bit replaying);
		logic [1:0] req;
		case ($urandom_range(0, 2))
			0: req = REQ_RESEND;
			1: req = replaying ? REQ_BYTE : REQ_TICK;
			default: req = REQ_UNUSED;
		endcase
		send_item(make_item(req, 8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095))));
	endtask

	task automatic replay_segment(input bit may_abandon);
		int total;
		int seg;
		int plen;
		int ticks;
		total = (frame_len + PAYLOAD_BYTES - 1) / PAYLOAD_BYTES;
		if ($urandom_range(0, 4) == 0)
			seg = $urandom_range(0, 1) ? 0 : $urandom_range(total + 1, 4095);
		else
			seg = $urandom_range(1, total);
		send_item(make_item(REQ_RESEND, 8'($urandom_range(0, 255)), 12'(seg)));
		if (seg == 0 || seg > total) begin
			send_item(make_item(REQ_TICK, 8'($urandom_range(0, 255)),
				12'($urandom_range(0, 4095))));
		end else begin
			stim_count++;
			plen = frame_len - (seg - 1) * PAYLOAD_BYTES;
			if (plen > PAYLOAD_BYTES)
				plen = PAYLOAD_BYTES;
			plen += HEADER_BYTES;
			ticks = (may_abandon && $urandom_range(0, 3) == 0) ? $urandom_range(1, plen - 1)
				: plen;
			for (int t = 0; t < ticks; t++) begin
				if ($urandom_range(0, 11) == 0)
					send_noise(1'b1);
				send_item(make_item(REQ_TICK, 8'($urandom_range(0, 255)),
					12'($urandom_range(0, 4095))));
				stim_count++;
			end
		end
	endtask

	// a frame of sent_bytes image bytes; a complete frame is followed by resends
	task automatic run_frame(input int value, input int sent_bytes);
		int rounds;
		write_length(value);
		for (int i = 0; i < sent_bytes; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_noise(1'b0);
			if ($urandom_range(0, 99) == 0)
				wait_drained();
			send_item(make_item(REQ_BYTE, 8'($urandom_range(0, 255)),
				12'($urandom_range(0, 4095))));
			stim_count++;
		end
		if (sent_bytes == value) begin
			repeat ($urandom_range(0, 2))
				send_item(make_item(REQ_BYTE, 8'($urandom_range(0, 255)), 12'h000));
			rounds = $urandom_range(1, 3);
			for (int r = 0; r < rounds; r++)
				replay_segment(r == rounds - 1);
		end
	endtask

	initial begin
		tx_calm = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		write_length(IMAGE_DEPTH);
		send_item(make_item(REQ_BYTE, 8'h00, 12'h000));
		send_item(make_item(REQ_BYTE, 8'hFF, 12'hFFF));
		send_item(make_item(REQ_RESEND, 8'h00, 12'h001));
		send_item(make_item(REQ_TICK, 8'h00, 12'h000));
		send_item(make_item(REQ_UNUSED, 8'hFF, 12'hFFF));

		write_length(1);
		send_item(make_item(REQ_RESEND, 8'h00, 12'h001));
		send_item(make_item(REQ_BYTE, 8'h5A, 12'h000));
		send_item(make_item(REQ_BYTE, 8'hC3, 12'h000));
		send_item(make_item(REQ_RESEND, 8'h00, 12'h000));
		send_item(make_item(REQ_RESEND, 8'h00, 12'h002));
		send_item(make_item(REQ_RESEND, 8'h00, 12'hFFF));
		send_item(make_item(REQ_RESEND, 8'h00, 12'h001));
		send_item(make_item(REQ_RESEND, 8'h00, 12'h001));
		repeat (HEADER_BYTES + 2)
			send_item(make_item(REQ_TICK, 8'h00, 12'h000));

		stim_count = 0;
		while (stim_count < RANDOM_ITEMS) begin
			len = ($urandom_range(0, 5) == 0) ? $urandom_range(41, 64) : $urandom_range(1, 24);
			run_frame(len, ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : len);
		end

		wait_drained();
		if (errors == 0 && waiting == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: files.f
src/isp_pkg.sv
src/isp_ram.sv
src/isp_setup.sv
src/isp_emit.sv
src/image_segment_packetizer.sv
tb/sv/image_segment_packetizer_check.sv
tb/sv/image_segment_packetizer_tb.sv
